>>> sv/header_tail_frame_extractor_core_defines.svh
// Assertion macros shared by the frame extractor RTL.
`ifndef HEADER_TAIL_FRAME_EXTRACTOR_CORE_DEFINES_SVH
`define HEADER_TAIL_FRAME_EXTRACTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and held off during reset.
`define HTFE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk and held off during reset.
`define HTFE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HTFE_ASSERT_IMP(lbl, ante, cons, msg)
`define HTFE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/htfe_pkg.sv
// Shared types and constants of the header/tail frame extractor.
package htfe_pkg;

	localparam int BYTE_W      = 8;
	localparam int CUST_TAIL_W = 16;
	localparam int SYS_TAIL_W  = 32;
	localparam int LEN_W       = 6;
	localparam int IDX_W       = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int FRAME_MAX_DEF = 32;

	localparam logic [BYTE_W-1:0]      HEADER_RST      = 8'hAA;
	localparam logic [CUST_TAIL_W-1:0] CUST_TRAILER_RST = 16'hEB90;
	localparam logic [SYS_TAIL_W-1:0]  SYS_TRAILER_RST  = 32'h0000_EB90;
	localparam logic [LEN_W-1:0]       MAX_LEN_RST      = 6'd32;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CUSTOM_HEADER  = 3'd0,
		CFG_CUSTOM_TRAILER = 3'd1,
		CFG_SYSTEM_HEADER  = 3'd2,
		CFG_SYSTEM_TRAILER = 3'd3,
		CFG_MAX_FRAME_LEN  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0]      custom_header;
		logic [CUST_TAIL_W-1:0] custom_trailer;
		logic [BYTE_W-1:0]      system_header;
		logic [SYS_TAIL_W-1:0]  system_trailer;
		logic [LEN_W-1:0]       max_frame_len;
	} cfg_t;

	// Controller status seen by the top-level checks.
	typedef struct packed {
		logic busy;
		logic wr_en;
		logic rd_issue;
		logic frame_done;
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

endpackage

>>> sv/htfe_in_if.sv
// Input channel: one tagged received byte per item.
interface htfe_in_if;
	import htfe_pkg::*;

	logic              valid;
	logic              ready;
	logic              mode;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

>>> sv/htfe_out_if.sv
// Output channel: one byte of a completed frame per item.
interface htfe_out_if;
	import htfe_pkg::*;

	logic              valid;
	logic              ready;
	logic              frame_channel;
	logic [BYTE_W-1:0] frame_byte;
	logic [IDX_W-1:0]  byte_index;
	logic [LEN_W-1:0]  frame_length;
	logic              last;

	modport source (output valid, output frame_channel, output frame_byte,
		output byte_index, output frame_length, output last, input ready);
	modport sink (input valid, input frame_channel, input frame_byte,
		input byte_index, input frame_length, input last, output ready);
endinterface

>>> sv/htfe_cfg_regs.sv
// Configuration register bank of the frame extractor.
module htfe_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [htfe_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [htfe_pkg::CFG_DATA_W-1:0] wr_data,
	output htfe_pkg::cfg_t                 cfg
);
	import htfe_pkg::*;

	cfg_t cfg_q;

	// Register writes, decoded by index; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.custom_header  <= HEADER_RST;
			cfg_q.custom_trailer <= CUST_TRAILER_RST;
			cfg_q.system_header  <= HEADER_RST;
			cfg_q.system_trailer <= SYS_TRAILER_RST;
			cfg_q.max_frame_len  <= MAX_LEN_RST;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_CUSTOM_HEADER:  cfg_q.custom_header  <= wr_data[BYTE_W-1:0];
				CFG_CUSTOM_TRAILER: cfg_q.custom_trailer <= wr_data[CUST_TAIL_W-1:0];
				CFG_SYSTEM_HEADER:  cfg_q.system_header  <= wr_data[BYTE_W-1:0];
				CFG_SYSTEM_TRAILER: cfg_q.system_trailer <= wr_data[SYS_TAIL_W-1:0];
				CFG_MAX_FRAME_LEN:  cfg_q.max_frame_len  <= wr_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> sv/htfe_frame_ram.sv
// Frame store: one write port and one registered read port.
module htfe_frame_ram #(
	parameter int ADDR_W = 6
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [ADDR_W-1:0]          wr_addr,
	input  logic [htfe_pkg::BYTE_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [ADDR_W-1:0]          rd_addr,
	output logic [htfe_pkg::BYTE_W-1:0] rd_data
);
	import htfe_pkg::*;

	logic [BYTE_W-1:0] mem [2**ADDR_W];
	logic [BYTE_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds between reads.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

>>> sv/htfe_frame_ctrl.sv
// Per-channel fill and tail tracking, store writes and frame readout.
module htfe_frame_ctrl #(
	parameter int FRAME_MAX = htfe_pkg::FRAME_MAX_DEF,
	parameter int ADDR_W    = $clog2(FRAME_MAX) + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  htfe_pkg::cfg_t             cfg,
	htfe_in_if.sink                    in_ch,
	htfe_out_if.source                 out_ch,
	output logic                       mem_wr_en,
	output logic [ADDR_W-1:0]          mem_wr_addr,
	output logic [htfe_pkg::BYTE_W-1:0] mem_wr_data,
	output logic                       mem_rd_en,
	output logic [ADDR_W-1:0]          mem_rd_addr,
	input  logic [htfe_pkg::BYTE_W-1:0] mem_rd_data,
	output htfe_pkg::status_t          status
);
	import htfe_pkg::*;

	localparam int POS_W = ADDR_W - 1;
	localparam int CNT_W = $clog2(FRAME_MAX + 1);

	state_t state_q, state_nx;

	logic [CNT_W-1:0]       cust_fill_q, sys_fill_q;
	logic [CUST_TAIL_W-1:0] cust_tail_q;
	logic [SYS_TAIL_W-1:0]  sys_tail_q;

	logic                   run_ch_q;
	logic [CNT_W-1:0]       run_len_q;
	logic [CNT_W-1:0]       rd_cnt_q;

	logic                   pend_s1;
	logic [CNT_W-1:0]       idx_s1;
	logic                   last_s1;

	logic                   out_valid_q;
	logic                   out_ch_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic [IDX_W-1:0]       out_idx_q;
	logic [LEN_W-1:0]       out_len_q;
	logic                   out_last_q;

	logic [CNT_W-1:0]       limit;
	logic [CNT_W-1:0]       cur_fill;
	logic [BYTE_W-1:0]      cur_hdr;
	logic                   acc;
	logic                   take;
	logic                   do_store;
	logic [CNT_W-1:0]       new_fill;
	logic [CUST_TAIL_W-1:0] cust_tail_nx;
	logic [SYS_TAIL_W-1:0]  sys_tail_nx;
	logic                   match;
	logic                   frame_done;
	logic                   out_free;
	logic                   s1_move;
	logic                   rd_issue;
	logic                   reads_left;

	// Frame limit in force: the register clamped to 1..FRAME_MAX.
	always_comb begin
		if (cfg.max_frame_len == '0) begin
			limit = CNT_W'(1);
		end else if (int'(cfg.max_frame_len) > FRAME_MAX) begin
			limit = CNT_W'(FRAME_MAX);
		end else begin
			limit = CNT_W'(cfg.max_frame_len);
		end
	end

	// Decision for the byte at the input: drop, store, and close the frame.
	always_comb begin
		acc          = in_ch.valid && in_ch.ready;
		cur_fill     = in_ch.mode ? sys_fill_q : cust_fill_q;
		cur_hdr      = in_ch.mode ? cfg.system_header : cfg.custom_header;
		take         = acc && !(cur_fill == '0 && in_ch.rx_byte != cur_hdr);
		do_store     = take && (cur_fill < limit);
		new_fill     = do_store ? cur_fill + CNT_W'(1) : cur_fill;
		cust_tail_nx = {cust_tail_q[CUST_TAIL_W-BYTE_W-1:0], in_ch.rx_byte};
		sys_tail_nx  = {sys_tail_q[SYS_TAIL_W-BYTE_W-1:0], in_ch.rx_byte};
		match        = in_ch.mode ? (sys_tail_nx == cfg.system_trailer)
		                          : (cust_tail_nx == cfg.custom_trailer);
		frame_done   = take && match;
	end

	// Store write for an accepted byte below the limit.
	assign mem_wr_en   = do_store;
	assign mem_wr_addr = {in_ch.mode, cur_fill[POS_W-1:0]};
	assign mem_wr_data = in_ch.rx_byte;

	// Readout: in a run with reads left, issue a read whenever the read stage will be free.
	always_comb begin
		out_free    = !out_valid_q || out_ch.ready;
		s1_move     = pend_s1 && out_free;
		reads_left  = rd_cnt_q < run_len_q;
		rd_issue    = (state_q == ST_EMIT) && reads_left && (!pend_s1 || s1_move);
		mem_rd_en   = rd_issue;
		mem_rd_addr = {run_ch_q, rd_cnt_q[POS_W-1:0]};
	end

	// Next-state logic.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (frame_done) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!reads_left && !pend_s1) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// State outputs: input is held off while a frame is read out.
	always_comb begin
		case (state_q)
			ST_IDLE: in_ch.ready = 1'b1;
			ST_EMIT: in_ch.ready = 1'b0;
			default: in_ch.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Fill and tail registers of both channels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cust_fill_q <= '0;
			sys_fill_q  <= '0;
			cust_tail_q <= '0;
			sys_tail_q  <= '0;
		end else if (take) begin
			if (in_ch.mode) begin
				sys_fill_q <= match ? '0 : new_fill;
				sys_tail_q <= match ? '0 : sys_tail_nx;
			end else begin
				cust_fill_q <= match ? '0 : new_fill;
				cust_tail_q <= match ? '0 : cust_tail_nx;
			end
		end
	end

	// Run descriptor and read counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_ch_q  <= 1'b0;
			run_len_q <= '0;
			rd_cnt_q  <= '0;
		end else if (frame_done) begin
			run_ch_q  <= in_ch.mode;
			run_len_q <= new_fill;
			rd_cnt_q  <= '0;
		end else if (rd_issue) begin
			rd_cnt_q <= rd_cnt_q + CNT_W'(1);
		end
	end

	// Read stage: tracks the item whose store data is arriving.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (rd_issue) begin
			pend_s1 <= 1'b1;
		end else if (s1_move) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			idx_s1  <= rd_cnt_q;
			last_s1 <= (rd_cnt_q + CNT_W'(1)) == run_len_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_ch_q   <= run_ch_q;
			out_byte_q <= mem_rd_data;
			out_idx_q  <= idx_s1[IDX_W-1:0];
			out_len_q  <= LEN_W'(run_len_q);
			out_last_q <= last_s1;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.frame_channel = out_ch_q;
	assign out_ch.frame_byte    = out_byte_q;
	assign out_ch.byte_index    = out_idx_q;
	assign out_ch.frame_length  = out_len_q;
	assign out_ch.last          = out_last_q;

	assign status.busy       = (state_q == ST_EMIT);
	assign status.wr_en      = do_store;
	assign status.rd_issue   = rd_issue;
	assign status.frame_done = frame_done;
endmodule

>>> sv/header_tail_frame_extractor_core.sv
// A closing byte moves the control state to the run state; the run's first byte then passes the store
// read register and the output register. Throughput: one input byte per cycle outside a run; a run
// sends one byte per cycle from the store while the output is not stalled. During a run the input waits
// for one store read per byte, the read register and the return to idle, and for every output stall.
// Reset clears fills, tail registers and control state and loads the default configuration;
// store contents stay undefined.
`include "header_tail_frame_extractor_core_defines.svh"

module header_tail_frame_extractor_core #(
	parameter int FRAME_MAX = htfe_pkg::FRAME_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	htfe_in_if.sink                        in_ch,
	htfe_out_if.source                     out_ch,
	input  logic                           wr_en,
	input  logic [htfe_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [htfe_pkg::CFG_DATA_W-1:0] wr_data
);
	import htfe_pkg::*;

	localparam int ADDR_W = $clog2(FRAME_MAX) + 1;

	cfg_t              cfg;
	status_t           status;
	logic              mem_wr_en;
	logic [ADDR_W-1:0] mem_wr_addr;
	logic [BYTE_W-1:0] mem_wr_data;
	logic              mem_rd_en;
	logic [ADDR_W-1:0] mem_rd_addr;
	logic [BYTE_W-1:0] mem_rd_data;

	htfe_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	htfe_frame_ram #(
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	htfe_frame_ctrl #(
		.FRAME_MAX (FRAME_MAX),
		.ADDR_W    (ADDR_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.status      (status)
	);

	// The store is never written while a run is read out of it.
	`HTFE_ASSERT_IMP(a_no_wr_in_run, status.wr_en, !status.busy, "store write during readout")
	// Reads happen only inside a run.
	`HTFE_ASSERT_IMP(a_rd_in_run, status.rd_issue, status.busy, "store read outside a run")
	// A closing byte stops input in the next cycle.
	`HTFE_ASSERT_NXT(a_close_stalls, status.frame_done, !in_ch.ready, "input open after frame end")
	// While a run has bytes still to come, no input is taken.
	`HTFE_ASSERT_IMP(a_run_blocks_in, out_ch.valid && !out_ch.last, !in_ch.ready,
		"input open inside a run")
endmodule

>>> sim/tb_header_tail_frame_extractor_core.sv
// Self-checking testbench for the two-channel header/tail frame extractor.
`timescale 1ns / 100ps

module tb_header_tail_frame_extractor_core;
	import htfe_pkg::*;

	localparam int FRAME_MAX   = FRAME_MAX_DEF;
	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 6;
	localparam int PHASE_ITEMS = 40;
	localparam int UNTYPED     = -1;

	// One directed byte; run_len is the typed run length it closes, or UNTYPED.
	typedef struct packed {
		logic              mode;
		logic [7:0]        rx_byte;
		logic signed [7:0] run_len;
	} dir_row_t;

	// One byte of a completed frame as it should leave the block.
	typedef struct packed {
		logic       ch;
		logic [7:0] data;
		logic [4:0] idx;
		logic [5:0] len;
		logic       last;
	} frame_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	htfe_in_if  in_if ();
	htfe_out_if out_if ();

	header_tail_frame_extractor_core #(.FRAME_MAX(FRAME_MAX)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_if),
		.out_ch   (out_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Deframer shadow state: configuration, per-channel store, fill and tail.
	cfg_t        cfg_now;
	logic [7:0]  frame_mem [2][FRAME_MAX];
	int unsigned frame_fill [2];
	logic [31:0] tail_reg [2];
	frame_beat_t expected_beats [$];
	frame_beat_t got_beat;
	frame_beat_t want_beat;

	int          row_frame_len;
	int          send_idle_pct;
	int          stall_pct;
	int          hold_left;
	int          cycle_count;
	int          mismatches;
	int          items_taken;
	int          beats_checked;
	int          runs_seen [2];

	dir_row_t directed_rows [22] = '{
		'{1'b0, 8'h55, 8'sd0},
		'{1'b1, 8'hFF, 8'sd0},
		'{1'b0, 8'hAA, 8'sd0},
		'{1'b0, 8'hEB, 8'sd0},
		'{1'b0, 8'h90, 8'sd3},
		'{1'b1, 8'hAA, 8'sd0},
		'{1'b1, 8'h00, 8'sd0},
		'{1'b1, 8'hFF, 8'sd0},
		'{1'b1, 8'h00, 8'sd0},
		'{1'b1, 8'h00, 8'sd0},
		'{1'b1, 8'hEB, 8'sd0},
		'{1'b1, 8'h90, 8'sd7},
		'{1'b0, 8'hAA, 8'sd0},
		'{1'b1, 8'hAA, 8'sd0},
		'{1'b0, 8'h00, -8'sd1},
		'{1'b1, 8'h12, -8'sd1},
		'{1'b0, 8'hEB, 8'sd0},
		'{1'b0, 8'h90, 8'sd4},
		'{1'b1, 8'h00, -8'sd1},
		'{1'b1, 8'h00, -8'sd1},
		'{1'b1, 8'hEB, 8'sd0},
		'{1'b1, 8'h90, 8'sd6}
	};

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Stored bytes allowed per frame: the length register clamped to 1..FRAME_MAX.
	function automatic int unsigned frame_limit();
		int unsigned lim;
		lim = 32'(cfg_now.max_frame_len);
		if (lim < 1)
			lim = 1;
		if (lim > FRAME_MAX)
			lim = FRAME_MAX;
		return lim;
	endfunction

	// Applies one accepted byte to the shadow state and queues the frame bytes it releases.
	// A typed run length, when given, decides how many bytes are expected.
	task automatic deframe(input logic ch, input logic [7:0] b, input int typed_len);
		logic [31:0] t;
		logic        hit;
		logic [7:0]  hdr;
		int          n;
		int          k;
		hdr = ch ? cfg_now.system_header : cfg_now.custom_header;
		// Outside a frame only the header byte gets in.
		if (frame_fill[ch] == 0 && b != hdr)
			return;
		if (frame_fill[ch] < frame_limit()) begin
			frame_mem[ch][frame_fill[ch]] = b;
			frame_fill[ch]++;
		end
		t = {tail_reg[ch][23:0], b};
		if (ch == 1'b0)
			t[31:16] = '0;
		tail_reg[ch] = t;
		hit = ch ? (t == cfg_now.system_trailer) : (t[15:0] == cfg_now.custom_trailer);
		if (typed_len >= 0)
			n = typed_len;
		else
			n = hit ? int'(frame_fill[ch]) : 0;
		for (k = 0; k < n; k++) begin
			expected_beats.push_back('{ch, frame_mem[ch][k], k[4:0], n[5:0], k == n - 1});
		end
		if (hit) begin
			frame_fill[ch] = 0;
			tail_reg[ch] = '0;
			runs_seen[ch]++;
		end
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch on %s at cycle %0d: expected 0x%0h, got 0x%0h",
					name, cycle_count, want, got);
		end
	endtask

	// Compare finished frame bytes, then fold accepted input bytes into the shadow state.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_if.valid && out_if.ready) begin
				got_beat = '{out_if.frame_channel, out_if.frame_byte, out_if.byte_index,
					out_if.frame_length, out_if.last};
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected frame byte 0x%0h on channel %0d at cycle %0d",
							got_beat.data, got_beat.ch, cycle_count);
				end else begin
					want_beat = expected_beats.pop_front();
					beats_checked++;
					check_field("frame_channel", want_beat.ch, got_beat.ch);
					check_field("frame_byte", want_beat.data, got_beat.data);
					check_field("byte_index", want_beat.idx, got_beat.idx);
					check_field("frame_length", want_beat.len, got_beat.len);
					check_field("last", want_beat.last, got_beat.last);
				end
			end
			if (in_if.valid && in_if.ready) begin
				items_taken++;
				deframe(in_if.mode, in_if.rx_byte, row_frame_len);
			end
		end
	end

	// Output backpressure: a long hold-off when requested, random stalls otherwise.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Run-time guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout at cycle %0d with %0d frame bytes outstanding",
				cycle_count, expected_beats.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offers one item after an optional random gap and holds it until taken.
	task automatic push_byte(input logic m, input logic [7:0] b, input int typed_len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			@(negedge clk);
		end
		in_if.valid   <= 1'b1;
		in_if.mode    <= m;
		in_if.rx_byte <= b;
		row_frame_len <= typed_len;
		do
			@(posedge clk);
		while (!in_if.ready);
		@(negedge clk);
	endtask

	// Stops sending and waits until every expected frame byte has come out.
	task automatic wait_drain();
		in_if.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Writes all five registers back to back; the block must be idle.
	task automatic load_settings(input cfg_t s);
		cfg_idx_t     idx [5];
		logic [31:0]  val [5];
		int           i;
		idx = '{CFG_CUSTOM_HEADER, CFG_CUSTOM_TRAILER, CFG_SYSTEM_HEADER,
			CFG_SYSTEM_TRAILER, CFG_MAX_FRAME_LEN};
		val = '{32'(s.custom_header), 32'(s.custom_trailer), 32'(s.system_header),
			s.system_trailer, 32'(s.max_frame_len)};
		for (i = 0; i < 5; i++) begin
			wr_en    <= 1'b1;
			wr_index <= idx[i];
			wr_data  <= val[i];
			@(negedge clk);
		end
		wr_en <= 1'b0;
		cfg_now = s;
	endtask

	// Mostly well-formed frames with random content, plus noise, interleaving and bad tails.
	// The phase ends with a frame left open so the next settings land mid-frame.
	task automatic random_phase(input int idle_v, input int stall_v, input bit pause_mid);
		int         sent;
		int         plen;
		int         j;
		logic       ch;
		logic [7:0] hdr;
		logic [31:0] trl;
		bit         paused;
		send_idle_pct = idle_v;
		stall_pct     = stall_v;
		sent   = 0;
		paused = 0;
		while (sent < PHASE_ITEMS) begin
			if (pause_mid && !paused && sent >= PHASE_ITEMS / 2) begin
				wait_drain();
				paused = 1;
			end
			if ($urandom_range(99) < 12) begin
				push_byte(1'($urandom_range(1)), 8'($urandom_range(255)), UNTYPED);
			end else begin
				ch  = 1'($urandom_range(1));
				hdr = ch ? cfg_now.system_header : cfg_now.custom_header;
				trl = ch ? cfg_now.system_trailer : 32'(cfg_now.custom_trailer);
				plen = ($urandom_range(9) == 0) ? $urandom_range(40, 25) : $urandom_range(6);
				push_byte(ch, hdr, UNTYPED);
				sent++;
				for (j = 0; j < plen; j++) begin
					if ($urandom_range(7) == 0)
						push_byte(!ch, 8'($urandom_range(255)), UNTYPED);
					push_byte(ch, 8'($urandom_range(255)), UNTYPED);
					sent++;
				end
				// A damaged last tail byte leaves the frame running.
				if ($urandom_range(9) == 0)
					trl[7:0] = trl[7:0] ^ 8'h01;
				for (j = (ch ? 3 : 1); j >= 0; j--) begin
					push_byte(ch, trl[8*j +: 8], UNTYPED);
					sent++;
				end
			end
		end
		ch = 1'($urandom_range(1));
		push_byte(ch, ch ? cfg_now.system_header : cfg_now.custom_header, UNTYPED);
		for (j = $urandom_range(3, 1); j > 0; j--)
			push_byte(ch, 8'($urandom_range(255)), UNTYPED);
		wait_drain();
	endtask

	// Main sequence: reset, directed table, then phases under varied settings.
	initial begin
		cfg_t s;
		int   r;
		int   p;
		arst_n        = 1'b0;
		wr_en         = 1'b0;
		wr_index      = '0;
		wr_data       = '0;
		in_if.valid   = 1'b0;
		in_if.mode    = 1'b0;
		in_if.rx_byte = '0;
		out_if.ready  = 1'b0;
		row_frame_len = UNTYPED;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_left     = 0;
		cycle_count   = 0;
		mismatches    = 0;
		items_taken   = 0;
		beats_checked = 0;
		runs_seen     = '{0, 0};
		frame_fill    = '{0, 0};
		tail_reg      = '{32'd0, 32'd0};
		cfg_now       = '{HEADER_RST, CUST_TRAILER_RST, HEADER_RST, SYS_TRAILER_RST,
			MAX_LEN_RST};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under reset settings.
		for (r = 0; r < 22; r++)
			push_byte(directed_rows[r].mode, directed_rows[r].rx_byte,
				int'(directed_rows[r].run_len));
		wait_drain();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: s = '{8'h3C, 16'h0D0A, 8'h7E, 32'hDEAD_BEEF, 6'd32};
				1: s = '{8'h00, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 6'd1};
				2: s = '{8'hFF, 16'h0000, 8'h00, 32'h0000_0000, 6'd0};
				// A tail of zero then the header closes a frame on the header alone.
				3: s = '{8'hAA, 16'h00AA, 8'hA5, 32'($urandom), 6'd63};
				4: s = '{8'($urandom), 16'($urandom), 8'($urandom), 32'($urandom),
					6'($urandom_range(8, 3))};
				default: s = '{8'($urandom), 16'($urandom), 8'($urandom), 32'($urandom), 6'd2};
			endcase
			load_settings(s);
			case (p)
				0: random_phase(0, 0, 1'b1);
				1: random_phase(49, 0, 1'b0);
				2: random_phase(0, 49, 1'b0);
				3: random_phase(35, 35, 1'b0);
				4: begin
					// Long output hold-off while the input keeps offering items.
					@(posedge clk);
					hold_left = HOLD_CYCLES;
					@(negedge clk);
					random_phase(0, 0, 1'b0);
				end
				default: random_phase(0, 49, 1'b0);
			endcase
		end

		$display("Run covered %0d accepted bytes and %0d checked frame bytes",
			items_taken, beats_checked);
		$display("Frames seen: %0d custom, %0d system; %0d mismatches",
			runs_seen[0], runs_seen[1], mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
